// File: design/lhd_pkg.sv
// Shared types, constants and the kernel weight table of the Lanczos half downsampler.
`default_nettype none
package lhd_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int ROW_OUT_W = 11;
  localparam int COL_OUT_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;
  localparam int LREG_W    = 3;
  localparam int KERN_W    = 15;
  localparam int WGT_W     = 28;
  localparam int PIX_W     = 3 * SAMPLE_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LOBES  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  red_out;
    logic [SAMPLE_W-1:0]  green_out;
    logic [SAMPLE_W-1:0]  blue_out;
    logic [ROW_OUT_W-1:0] out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 run_last;
  } pix_out_t;

  // Lanczos weight at offset d+0.5 for half width am1+1, in Q1.14.
  function automatic logic signed [KERN_W-1:0] kern_w(input logic [2:0] am1,
                                                      input logic [2:0] d);
    logic signed [KERN_W-1:0] k;
    k = '0;
    case ({am1, d})
      6'o00: k = 15'sd6640;
      6'o10: k = 15'sd9391;
      6'o11: k = -15'sd1043;
      6'o20: k = 15'sd9960;
      6'o21: k = -15'sd2213;
      6'o22: k = 15'sd398;
      6'o30: k = 15'sd10164;
      6'o31: k = -15'sd2727;
      6'o32: k = 15'sd982;
      6'o33: k = -15'sd207;
      6'o40: k = 15'sd10260;
      6'o41: k = -15'sd2984;
      6'o42: k = 15'sd1328;
      6'o43: k = -15'sd548;
      6'o44: k = 15'sd127;
      6'o50: k = 15'sd10312;
      6'o51: k = -15'sd3130;
      6'o52: k = 15'sd1539;
      6'o53: k = -15'sd785;
      6'o54: k = 15'sd348;
      6'o55: k = -15'sd85;
      6'o60: k = 15'sd10343;
      6'o61: k = -15'sd3220;
      6'o62: k = 15'sd1675;
      6'o63: k = -15'sd949;
      6'o64: k = 15'sd517;
      6'o65: k = -15'sd240;
      6'o66: k = 15'sd61;
      6'o70: k = 15'sd10363;
      6'o71: k = -15'sd3279;
      6'o72: k = 15'sd1767;
      6'o73: k = -15'sd1063;
      6'o74: k = 15'sd643;
      6'o75: k = -15'sd365;
      6'o76: k = 15'sd175;
      6'o77: k = -15'sd46;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// File: design/lhd_div.sv
// Restoring divider with saturation for the normalization of one channel.
`default_nettype none
module lhd_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 36
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [NUM_W-1:0]             num_i,
  input  wire logic [DEN_W-1:0]             den_i,
  output logic                              done_o,
  output logic [lhd_pkg::SAMPLE_W-1:0]      quot_o
);
  import lhd_pkg::*;

  localparam int EW = (NUM_W > DEN_W + SAMPLE_W) ? NUM_W : DEN_W + SAMPLE_W;
  localparam int KW = $clog2(SAMPLE_W);

  logic          busy_q, done_q;
  logic [KW-1:0] k_q;
  logic [EW-1:0] rem_q, dv_q;
  logic [SAMPLE_W-1:0] quot_q;
  logic [EW-1:0] num_x, den_top, den_first;
  logic          ge;

  assign num_x     = EW'(num_i);
  assign den_top   = EW'(den_i) << SAMPLE_W;
  assign den_first = EW'(den_i) << (SAMPLE_W - 1);
  assign ge        = rem_q >= dv_q;

  // Sequencing: a quotient of one full sample range or more saturates at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_x >= den_top) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          k_q    <= KW'(SAMPLE_W - 1);
        end
      end else if (busy_q) begin
        if (k_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q - 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_x;
      dv_q   <= den_first;
      quot_q <= (num_x >= den_top) ? '1 : '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[SAMPLE_W-2:0], ge};
      if (ge) begin
        rem_q <= rem_q - dv_q;
      end
      dv_q <= dv_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// File: design/lanczos_half_downsampler_top.sv
// Top level: line store, tap sequencer, shared MAC and normalization of the downsampler.
//
//  channel | signals                                  | carries
//  --------+------------------------------------------+-------------------------------
//  in      | in_valid_i / in_ready_o / in_data_i      | one RGB input pixel, raster order
//  out     | out_valid_o / out_ready_i / out_data_o   | one half-size pixel with row/col
//  cfg     | cfg_we_i / cfg_idx_i / cfg_data_i        | width, height, lobes
//
// A pixel that completes no window leaves in_ready_o high. The cost of each result
// is set by the single MAC walking the window taps (up to 4*a*a) and the one
// divider shared by the three channels; up to four results follow one pixel.
// in_ready_o is low until the last result is taken. Reset clears counters and
// registers to width 1024, height 1024, a = 3.
`default_nettype none
module lanczos_half_downsampler_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_LOBES  = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lhd_pkg::pix_in_t                  in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lhd_pkg::pix_out_t                      out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lhd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lhd_pkg::CFG_W-1:0]         cfg_data_i
);
  import lhd_pkg::*;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + 1);
  localparam int PW     = ((CW > RW) ? CW : RW) + 2;
  localparam int RING   = 2 * MAX_LOBES;
  localparam int RGW    = $clog2(RING);
  localparam int MW     = $clog2(2 * MAX_LOBES);
  localparam int TB     = $clog2(4 * MAX_LOBES * MAX_LOBES);
  localparam int PROD_W = WGT_W + SAMPLE_W + 1;
  localparam int AW     = PROD_W + TB;
  localparam int SW     = WGT_W + TB;
  localparam int NUM_W  = AW + 1;
  localparam int DEN_W  = SW + 1;
  localparam int DEPTH  = 2 ** (RGW + XW);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PLAN  = 6'b000010,
    ST_TAPS  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic          ok;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
  } axis_t;

  // Output indexes on one axis whose clipped window ends at position p.
  function automatic axis_t axis_range(input logic [PW-1:0] p, input logic [PW-1:0] size,
                                       input logic [3:0] a);
    axis_t             res;
    logic [PW-1:0]     n;
    logic signed [PW:0] t;
    res = '0;
    n   = size >> 1;
    t   = '0;
    if (n != '0) begin
      if (p == size - 1'b1) begin
        t = $signed({1'b0, size}) - $signed((PW + 1)'(1)) - $signed((PW + 1)'(a));
        res.lo = (t <= 0) ? '0 : PW'(($unsigned(t) + (PW + 1)'(1)) >> 1);
        res.hi = n - 1'b1;
        res.ok = res.lo <= res.hi;
      end else begin
        t = $signed({1'b0, p}) - $signed((PW + 1)'(a));
        if (!t[PW] && !t[0] && (PW'($unsigned(t)) >> 1) < n) begin
          res.ok = 1'b1;
          res.lo = PW'($unsigned(t)) >> 1;
          res.hi = PW'($unsigned(t)) >> 1;
        end
      end
    end
    return res;
  endfunction

  // Distance of a window tap from the center, in whole pixels less one half.
  function automatic logic [2:0] tap_dist(input logic [MW-1:0] m, input logic [3:0] a);
    logic [4:0] mm;
    logic [4:0] d;
    mm = 5'(m);
    d  = (mm >= 5'(a)) ? mm - 5'(a) : 5'(a) - 5'd1 - mm;
    return d[2:0];
  endfunction

  // Configuration registers.
  logic [WREG_W-1:0] wreg_q;
  logic [HREG_W-1:0] hreg_q;
  logic [LREG_W-1:0] lreg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= WREG_W'(1024);
      hreg_q <= HREG_W'(1024);
      lreg_q <= LREG_W'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  wreg_q <= cfg_data_i[WREG_W-1:0];
        CFG_HEIGHT: hreg_q <= cfg_data_i[HREG_W-1:0];
        CFG_LOBES:  lreg_q <= cfg_data_i[LREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size and kernel width as used.
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [3:0]    a_eff;

  always_comb begin
    if (wreg_q == '0)                   w_eff = CW'(1);
    else if (32'(wreg_q) > MAX_WIDTH)   w_eff = CW'(MAX_WIDTH);
    else                                w_eff = CW'(wreg_q);
    if (hreg_q == '0)                   h_eff = RW'(1);
    else if (32'(hreg_q) > MAX_HEIGHT)  h_eff = RW'(MAX_HEIGHT);
    else                                h_eff = RW'(hreg_q);
    if (lreg_q == '0)                   a_eff = 4'd1;
    else if (32'(lreg_q) > MAX_LOBES)   a_eff = 4'(MAX_LOBES);
    else                                a_eff = 4'(lreg_q);
  end

  // Control registers.
  state_e         state_q, state_d;
  logic [XW-1:0]  col_q, col_d;
  logic [YW-1:0]  row_q, row_d;
  logic [RGW-1:0] ring_q, ring_d;
  logic [PW-1:0]  jc_q, jc_d, ic_q, ic_d;
  logic [1:0]     nout_q, nout_d;
  logic [1:0]     ch_q, ch_d;
  logic           div_busy_q, div_busy_d;
  logic           p1_v_q, p1_v_d;

  // Request bookkeeping latched per input pixel.
  logic [YW-1:0]  r_q;
  logic [XW-1:0]  c_q;
  logic [RGW-1:0] ringr_q;
  logic [PW-1:0]  jlo_q, jhi_q, ilo_q, ihi_q;

  // Window walk registers.
  logic [YW-1:0]  yy_q, yy_d;
  logic [XW-1:0]  xx_q, xx_d, x0_q, x0_d;
  logic [RGW-1:0] ry_q, ry_d;
  logic [MW-1:0]  my_q, my_d, mx_q, mx_d, mx0_q, mx0_d;

  // Datapath registers.
  logic signed [WGT_W-1:0] wgt_q;
  logic [PIX_W-1:0]        rd_q;
  logic signed [SW-1:0]    s_q;
  logic signed [AW-1:0]    acc_q [3];
  logic [SAMPLE_W-1:0]     res_q [3];
  logic [SAMPLE_W-1:0]     res_d [3];
  logic [PIX_W-1:0]        mem_q [DEPTH];

  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Position of the incoming pixel, with stale counters taken as zero.
  logic [XW-1:0]  cur_c;
  logic [YW-1:0]  cur_r;
  logic [RGW-1:0] cur_ring;
  logic           row_off;
  axis_t          ar, ac;

  always_comb begin
    cur_c    = (CW'(col_q) >= w_eff) ? '0 : col_q;
    row_off  = RW'(row_q) >= h_eff;
    cur_r    = row_off ? '0 : row_q;
    cur_ring = row_off ? '0 : ring_q;
    ar       = axis_range(PW'(cur_r), PW'(h_eff), a_eff);
    ac       = axis_range(PW'(cur_c), PW'(w_eff), a_eff);
  end

  // Window start for the current result.
  logic signed [PW+1:0] ylo, xlo;
  logic [YW-1:0]  y0, ydiff;
  logic [XW-1:0]  x0;
  logic [MW-1:0]  my0, mx0;
  logic [RGW-1:0] dr, ry0;

  always_comb begin
    ylo   = $signed((PW + 2)'({jc_q, 1'b0})) - $signed((PW + 2)'(a_eff)) + (PW + 2)'(1);
    xlo   = $signed((PW + 2)'({ic_q, 1'b0})) - $signed((PW + 2)'(a_eff)) + (PW + 2)'(1);
    y0    = (ylo < 0) ? '0 : ylo[YW-1:0];
    my0   = (ylo < 0) ? MW'(-ylo) : '0;
    x0    = (xlo < 0) ? '0 : xlo[XW-1:0];
    mx0   = (xlo < 0) ? MW'(-xlo) : '0;
    ydiff = r_q - y0;
    dr    = RGW'(ydiff);
    ry0   = (ringr_q >= dr) ? ringr_q - dr
                            : RGW'((RGW + 1)'(ringr_q) + (RGW + 1)'(RING) - (RGW + 1)'(dr));
  end

  // Tap weight from the kernel table.
  logic signed [KERN_W-1:0]   kv, kh;
  logic signed [2*KERN_W-1:0] wprod;
  always_comb begin
    kv    = kern_w(3'(a_eff - 4'd1), tap_dist(my_q, a_eff));
    kh    = kern_w(3'(a_eff - 4'd1), tap_dist(mx_q, a_eff));
    wprod = kv * kh;
  end

  // Normalization operands for the selected channel.
  logic signed [AW-1:0]    n_sel;
  logic signed [NUM_W-1:0] num_s;
  logic [DEN_W-1:0]        den;
  logic                    s_pos, n_pos;
  logic                    div_start, div_done;
  logic [SAMPLE_W-1:0]     div_quot;

  always_comb begin
    n_sel = acc_q[ch_q];
    s_pos = !s_q[SW-1] && (s_q != '0);
    n_pos = !n_sel[AW-1] && (n_sel != '0);
    num_s = $signed({n_sel, 1'b0}) + $signed({{(NUM_W - SW){s_q[SW-1]}}, s_q});
    den   = {s_q, 1'b0};
  end

  lhd_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ($unsigned(num_s)),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  logic last_res;
  assign last_res = (nout_q == 2'd3) || ((jc_q == jhi_q) && (ic_q == ihi_q));

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    ring_d     = ring_q;
    jc_d       = jc_q;
    ic_d       = ic_q;
    nout_d     = nout_q;
    ch_d       = ch_q;
    div_busy_d = div_busy_q;
    p1_v_d     = 1'b0;
    yy_d       = yy_q;
    xx_d       = xx_q;
    x0_d       = x0_q;
    ry_d       = ry_q;
    my_d       = my_q;
    mx_d       = mx_q;
    mx0_d      = mx0_q;
    div_start  = 1'b0;
    res_d      = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (CW'(cur_c) + CW'(1) >= w_eff) begin
            col_d = '0;
            if (RW'(cur_r) + RW'(1) >= h_eff) begin
              row_d  = '0;
              ring_d = '0;
            end else begin
              row_d  = cur_r + 1'b1;
              ring_d = (cur_ring == RGW'(RING - 1)) ? '0 : cur_ring + 1'b1;
            end
          end else begin
            col_d = cur_c + 1'b1;
            row_d = cur_r;
            ring_d = cur_ring;
          end
          jc_d   = ar.lo;
          ic_d   = ac.lo;
          nout_d = '0;
          if (ar.ok && ac.ok) state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        yy_d    = y0;
        xx_d    = x0;
        x0_d    = x0;
        ry_d    = ry0;
        my_d    = my0;
        mx_d    = mx0;
        mx0_d   = mx0;
        state_d = ST_TAPS;
      end
      ST_TAPS: begin
        p1_v_d = 1'b1;
        if (xx_q == c_q) begin
          if (yy_q == r_q) begin
            state_d = ST_DRAIN;
          end else begin
            xx_d = x0_q;
            mx_d = mx0_q;
            yy_d = yy_q + 1'b1;
            my_d = my_q + 1'b1;
            ry_d = (ry_q == RGW'(RING - 1)) ? '0 : ry_q + 1'b1;
          end
        end else begin
          xx_d = xx_q + 1'b1;
          mx_d = mx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        ch_d       = '0;
        div_busy_d = 1'b0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy_q) begin
          if (s_pos && n_pos) begin
            div_start  = 1'b1;
            div_busy_d = 1'b1;
          end else begin
            res_d[ch_q] = '0;
            if (ch_q == 2'd2) state_d = ST_OUT;
            else              ch_d = ch_q + 1'b1;
          end
        end else if (div_done) begin
          res_d[ch_q] = div_quot;
          div_busy_d  = 1'b0;
          if (ch_q == 2'd2) state_d = ST_OUT;
          else              ch_d = ch_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (last_res) begin
            state_d = ST_IDLE;
          end else begin
            nout_d  = nout_q + 1'b1;
            state_d = ST_PLAN;
            if (ic_q == ihi_q) begin
              ic_d = ilo_q;
              jc_d = jc_q + 1'b1;
            end else begin
              ic_d = ic_q + 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      ring_q     <= '0;
      jc_q       <= '0;
      ic_q       <= '0;
      nout_q     <= '0;
      ch_q       <= '0;
      div_busy_q <= 1'b0;
      p1_v_q     <= 1'b0;
      yy_q       <= '0;
      xx_q       <= '0;
      x0_q       <= '0;
      ry_q       <= '0;
      my_q       <= '0;
      mx_q       <= '0;
      mx0_q      <= '0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      ring_q     <= ring_d;
      jc_q       <= jc_d;
      ic_q       <= ic_d;
      nout_q     <= nout_d;
      ch_q       <= ch_d;
      div_busy_q <= div_busy_d;
      p1_v_q     <= p1_v_d;
      yy_q       <= yy_d;
      xx_q       <= xx_d;
      x0_q       <= x0_d;
      ry_q       <= ry_d;
      my_q       <= my_d;
      mx_q       <= mx_d;
      mx0_q      <= mx0_d;
    end
  end

  // Per-pixel request bookkeeping.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q     <= cur_r;
      c_q     <= cur_c;
      ringr_q <= cur_ring;
      jlo_q   <= ar.lo;
      jhi_q   <= ar.hi;
      ilo_q   <= ac.lo;
      ihi_q   <= ac.hi;
    end
  end

  // Line store: written on accept, read one tap per cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[{cur_ring, cur_c}] <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    end
    rd_q <= mem_q[{ry_q, xx_q}];
  end

  // Weight product and the shared multiply-accumulate.
  logic signed [PROD_W-1:0] prod [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = wgt_q * $signed({1'b0, rd_q[PIX_W-1-k*SAMPLE_W -: SAMPLE_W]});
    end
  end

  always_ff @(posedge clk_i) begin
    wgt_q <= wprod[WGT_W-1:0];
    res_q <= res_d;
    if (state_q == ST_PLAN) begin
      s_q <= '0;
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    end else if (p1_v_q) begin
      s_q <= s_q + {{(SW - WGT_W){wgt_q[WGT_W-1]}}, wgt_q};
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= acc_q[k] + {{(AW - PROD_W){prod[k][PROD_W-1]}}, prod[k]};
      end
    end
  end

  // Result register.
  logic [31:0] jc32, ic32;
  assign jc32 = 32'(jc_q);
  assign ic32 = 32'(ic_q);

  assign out_valid_o          = (state_q == ST_OUT);
  assign out_data_o.red_out   = res_q[0];
  assign out_data_o.green_out = res_q[1];
  assign out_data_o.blue_out  = res_q[2];
  assign out_data_o.out_row   = jc32[ROW_OUT_W-1:0];
  assign out_data_o.out_col   = ic32[COL_OUT_W-1:0];
  assign out_data_o.run_last  = last_res;

endmodule
`default_nettype wire
